>>> src/psmd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package psmd_pkg;

    localparam int PKT_QUEUE_DEPTH = 2;

    localparam logic MODE_3BYTE = 1'b0;
    localparam logic MODE_4BYTE = 1'b1;

    localparam logic [1:0] IDX_Y_BYTE = 2'd2;
    localparam logic [1:0] IDX_Z_BYTE = 2'd3;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    typedef enum logic {
        EV_BUTTON = 1'b0,
        EV_MOVE   = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic [2:0]        buttons;
        logic [2:0]        changed;
        logic signed [8:0] move_x;
        logic signed [8:0] move_y;
        logic signed [7:0] move_z;
    } t_pkt_rec;

    typedef struct packed {
        t_event_kind       event_kind;
        logic [1:0]        button_index;
        logic              pressed;
        logic signed [8:0] move_x;
        logic signed [8:0] move_y;
        logic signed [7:0] move_z;
        logic              last_of_packet;
    } t_event;

endpackage

>>> src/psmd_front.sv
// Front end: gathers bytes into packets and produces one record per packet.
module psmd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_byte_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_queue_full,
    output logic               o_byte_ready,
    output logic               o_push,
    output psmd_pkg::t_pkt_rec o_rec
);
    import psmd_pkg::*;

    logic       r_wheel_mode;
    logic [1:0] r_byte_index;
    logic [1:0] n_byte_index;
    logic [2:0] r_held;
    logic [2:0] n_held;
    logic [7:0] r_store [3];
    logic       accept;
    logic       complete;
    logic [7:0] hdr;
    logic [7:0] y_byte;

    assign o_byte_ready = !i_queue_full;
    assign accept       = i_byte_valid && !i_queue_full;

    always_comb begin
        if (r_wheel_mode == MODE_4BYTE) begin
            complete = (r_byte_index == IDX_Z_BYTE);
        end else begin
            complete = (r_byte_index >= IDX_Y_BYTE);
        end
    end

    assign hdr    = r_store[0];
    assign y_byte = (r_wheel_mode == MODE_4BYTE) ? r_store[2] : i_byte;

    always_comb begin
        o_rec.buttons = hdr[2:0];
        o_rec.changed = hdr[2:0] ^ r_held;
        o_rec.move_x  = {hdr[HDR_X_SIGN], r_store[1]};
        o_rec.move_y  = {hdr[HDR_Y_SIGN], y_byte};
        o_rec.move_z  = (r_wheel_mode == MODE_4BYTE) ? i_byte : 8'sd0;
    end

    assign o_push = accept && complete;

    always_comb begin
        n_byte_index = r_byte_index;
        n_held       = r_held;
        if (accept) begin
            if (complete) begin
                n_byte_index = 2'd0;
                n_held       = hdr[2:0];
            end else begin
                n_byte_index = r_byte_index + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= MODE_3BYTE;
            r_byte_index <= 2'd0;
            r_held       <= 3'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wheel_mode <= i_cfg_wr_data;
            end
            r_byte_index <= n_byte_index;
            r_held       <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !complete) begin
            r_store[r_byte_index] <= i_byte;
        end
    end

endmodule

>>> src/psmd_queue.sv
// Small first-word-fall-through queue of packet records.
module psmd_queue #(
    parameter int DEPTH = psmd_pkg::PKT_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  psmd_pkg::t_pkt_rec i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output psmd_pkg::t_pkt_rec o_data
);
    import psmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pkt_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/psmd_back.sv
// Back end: turns one packet record into button and movement events.
module psmd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rec_valid,
    input  psmd_pkg::t_pkt_rec i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output psmd_pkg::t_event   o_event
);
    import psmd_pkg::*;

    t_pkt_rec   r_cur;
    logic       r_busy;
    logic [2:0] r_pending;
    logic [2:0] n_pending;
    logic       r_out_valid;
    t_event     r_out;
    t_event     ev;
    logic [2:0] clr_mask;
    logic       slot_free;
    logic       emit;
    logic       finish;

    assign slot_free = !r_out_valid || i_ready;
    assign emit      = r_busy && slot_free;
    assign finish    = emit && (r_pending == 3'd0);
    assign o_pop     = i_rec_valid && (!r_busy || finish);

    always_comb begin
        ev                = '0;
        clr_mask          = 3'd0;
        ev.event_kind     = EV_BUTTON;
        if (r_pending[0]) begin
            ev.button_index = BTN_LEFT;
            ev.pressed      = r_cur.buttons[0];
            clr_mask        = 3'b001;
        end else if (r_pending[1]) begin
            ev.button_index = BTN_RIGHT;
            ev.pressed      = r_cur.buttons[1];
            clr_mask        = 3'b010;
        end else if (r_pending[2]) begin
            ev.button_index = BTN_MIDDLE;
            ev.pressed      = r_cur.buttons[2];
            clr_mask        = 3'b100;
        end else begin
            ev.event_kind     = EV_MOVE;
            ev.move_x         = r_cur.move_x;
            ev.move_y         = r_cur.move_y;
            ev.move_z         = r_cur.move_z;
            ev.last_of_packet = 1'b1;
        end
    end

    always_comb begin
        n_pending = r_pending;
        if (o_pop) begin
            n_pending = i_rec.changed;
        end else if (emit) begin
            n_pending = r_pending & ~clr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pending   <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            r_pending <= n_pending;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_rec;
        end
        if (emit) begin
            r_out <= ev;
        end
    end

    assign o_valid = r_out_valid;
    assign o_event = r_out;

endmodule

>>> src/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder.
// Each packet's record is queued, loaded by the back end, and its events registered out.
// Throughput: one byte per cycle while the record queue has room; one event per cycle
// out while m_axis_tready is high, 1 to 4 events per packet.
// Reset: synchronous, active low; clears the byte position, held buttons, mode and queue.
module ps2_mouse_packet_decoder #(
    parameter int QUEUE_DEPTH = psmd_pkg::PKT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] button_index, [2] pressed, [11:3] move_x, [20:12] move_y,
    // [28:21] move_z, [31:29] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] event_kind
    output logic        m_axis_tlast    // last_of_packet
);
    import psmd_pkg::*;

    t_pkt_rec push_rec;
    t_pkt_rec head_rec;
    t_event   out_event;
    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;

    psmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_queue_full  (queue_full),
        .o_byte_ready  (s_axis_tready),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    psmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_data  (head_rec)
    );

    psmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!queue_empty),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_event     (out_event)
    );

    assign m_axis_tdata = {3'b000, out_event.move_z, out_event.move_y, out_event.move_x,
                           out_event.pressed, out_event.button_index};
    assign m_axis_tuser = out_event.event_kind;
    assign m_axis_tlast = out_event.last_of_packet;

endmodule

>>> src/psmd_checker.sv
// Port-level checks on the event stream of the decoder, bound to the top level.
module psmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import psmd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("event valid after reset");

    a_last_iff_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == EV_MOVE)))
        else $error("tlast does not match the movement event");

    a_button_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_BUTTON) |->
            (m_axis_tdata[31:3] == 29'd0 && m_axis_tdata[1:0] != 2'd3))
        else $error("bad button event fields");

    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_MOVE) |->
            (m_axis_tdata[2:0] == 3'd0 && m_axis_tdata[31:29] == 3'd0))
        else $error("bad movement event fields");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("event changed while stalled");

endmodule

bind ps2_mouse_packet_decoder psmd_checker u_psmd_checker (.*);
